FILE: rtl/pbo_pkg.sv
// Package: shared types and constants for the polyBLEP oscillator core.
`default_nettype none
package pbo_pkg;
  localparam int QBITS = 30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_BLEP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic blep_start;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_busy;
    logic div_done;
  } sts_t;
endpackage
`default_nettype wire

FILE: rtl/pbo_if.sv
// Interfaces: input, result and configuration channels.
`default_nettype none
interface pbo_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] phase_step;
  logic [23:0] pulse_width;
  logic        restart;
  logic [23:0] start_phase;
  modport source (output valid, phase_step, pulse_width, restart, start_phase, input ready);
  modport sink (input valid, phase_step, pulse_width, restart, start_phase, output ready);
endinterface

interface pbo_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] saw_out;
  logic signed [16:0] pulse_out;
  logic signed [16:0] core_out;
  logic               wrapped;
  modport source (output valid, saw_out, pulse_out, core_out, wrapped, input ready);
  modport sink (input valid, saw_out, pulse_out, core_out, wrapped, output ready);
endinterface

interface pbo_cfg_if;
  logic        valid;
  logic        ready;
  logic [23:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pbo_ctrl.sv
// Controller: sequences one item through load, residual evaluation and output.
`default_nettype none
module pbo_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_fire,
  input  wire logic            out_free,
  input  pbo_pkg::sts_t        sts,
  output pbo_pkg::cmd_t        cmd,
  output logic                 busy
);
  pbo_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= pbo_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pbo_pkg::ST_IDLE: if (in_fire) state_nxt = pbo_pkg::ST_LOAD;
      pbo_pkg::ST_LOAD: state_nxt = pbo_pkg::ST_BLEP;
      pbo_pkg::ST_BLEP: if (sts.div_done) state_nxt = pbo_pkg::ST_DONE;
      pbo_pkg::ST_DONE: if (out_free) state_nxt = pbo_pkg::ST_IDLE;
      default: state_nxt = pbo_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    busy = 1'b1;
    case (state_r)
      pbo_pkg::ST_IDLE: busy = 1'b0;
      pbo_pkg::ST_LOAD: cmd.blep_start = 1'b1;
      pbo_pkg::ST_BLEP: ;
      pbo_pkg::ST_DONE: cmd.finish = out_free;
      default: busy = 1'b0;
    endcase
    cmd.load = in_fire;
  end

  a_done_in_blep: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == pbo_pkg::ST_BLEP) else $error("div done out of state");
  a_fire_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |-> state_r == pbo_pkg::ST_IDLE) else $error("accept while busy");
  a_load_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r == pbo_pkg::ST_LOAD) else $error("load missed");
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == pbo_pkg::ST_IDLE |-> !sts.div_busy) else $error("divider busy while idle");
endmodule
`default_nettype wire

FILE: rtl/pbo_div.sv
// Restoring divider: quotient (num << QBITS) / den, one bit per cycle.
`default_nettype none
module pbo_div #(
  parameter int PHASE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [PHASE_BITS-1:0] num,
  input  wire logic [PHASE_BITS-1:0] den,
  output logic [pbo_pkg::QBITS-1:0]  quo,
  output logic                       busy,
  output logic                       done
);
  localparam int CW = $clog2(pbo_pkg::QBITS + 1);
  logic [PHASE_BITS:0]         rem_r, rem_nxt;
  logic [PHASE_BITS:0]         trial;
  logic [pbo_pkg::QBITS-1:0]   quo_r;
  logic [CW-1:0]               cnt_r;
  logic                        busy_r;
  logic                        done_r;

  always_comb begin
    trial = {rem_r[PHASE_BITS-1:0], 1'b0} - {1'b0, den};
    if (!trial[PHASE_BITS]) rem_nxt = trial;
    else rem_nxt = {rem_r[PHASE_BITS-1:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(pbo_pkg::QBITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= {1'b0, num};
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[pbo_pkg::QBITS-2:0], ~trial[PHASE_BITS]};
    end
  end

  assign quo  = quo_r;
  assign busy = busy_r;
  assign done = done_r;
endmodule
`default_nettype wire

FILE: rtl/pbo_dp.sv
// Datapath: phase accumulator, clamps, residual terms and output rounding.
`default_nettype none
module pbo_dp #(
  parameter int PHASE_BITS    = 24,
  parameter int OUT_FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  pbo_pkg::cmd_t           cmd,
  output pbo_pkg::sts_t           sts,
  input  wire logic [23:0]        phase_step,
  input  wire logic [23:0]        pulse_width,
  input  wire logic               restart,
  input  wire logic [23:0]        start_phase,
  input  wire logic [23:0]        duty_cfg,
  output logic signed [16:0]      saw_out,
  output logic signed [16:0]      pulse_out,
  output logic signed [16:0]      core_out,
  output logic                    wrapped
);
  localparam int PB = PHASE_BITS;
  localparam int Q  = pbo_pkg::QBITS;
  localparam logic [PB:0] PH_ONE = {1'b1, {PB{1'b0}}};
  localparam logic [PB-1:0] STEP_MAX = PB'((64'd49 << PB) / 64'd100);
  localparam logic [PB-1:0] PW_MIN = PB'((64'd3 << PB) / 64'd100);
  localparam logic [PB-1:0] PW_MAX = PB'((64'd97 << PB) / 64'd100);
  localparam int SH = Q - OUT_FRAC_BITS;
  localparam int VW = Q + 4;
  localparam int UP = (Q > PB) ? Q - PB : 0;
  localparam int DN = (PB > Q) ? PB - Q : 0;

  function automatic logic [PB-1:0] to_ph(input logic [23:0] x);
    logic [PB+23:0] w;
    w = {x, {PB{1'b0}}};
    return w[PB+23 -: PB];
  endfunction

  logic [PB-1:0] acc_r, p_r, dt_r, pw_r, duty_r;
  logic          wrap_r;
  // three residuals: p, p-pw, p-duty evaluated serially through one divider
  logic [1:0]    idx_r;
  logic          neg_r, act_r, full_r;
  logic [PB-1:0] num_r;
  logic signed [VW-1:0] b0_r, b1_r, b2_r;
  logic [Q-1:0]  quo;
  logic          dbusy, ddone, dstart_r;
  logic [2*Q-1:0] sq;
  logic signed [VW-1:0] bterm;

  logic [PB-1:0] dt_c, pw_c, p_c;
  logic [PB:0]   sum_c;

  always_comb begin
    dt_c = to_ph(phase_step);
    if (dt_c > STEP_MAX) dt_c = STEP_MAX;
    pw_c = to_ph(pulse_width);
    if (pw_c < PW_MIN) pw_c = PW_MIN;
    if (pw_c > PW_MAX) pw_c = PW_MAX;
    p_c = restart ? to_ph(start_phase) : acc_r;
    sum_c = {1'b0, p_c} + {1'b0, dt_c};
  end

  // residual setup for term idx on phase t
  function automatic logic [PB+1:0] setup(input logic [PB-1:0] t, input logic [PB-1:0] dt);
    logic [PB:0] s;
    s = {1'b0, t} + {1'b0, dt};
    if (t < dt) return {1'b1, 1'b1, PB'(dt - t)};
    if (s > PH_ONE) return {1'b1, 1'b0, PB'(s - PH_ONE)};
    return '0;
  endfunction

  // setup is for the term about to start: first on blep_start, else the next one
  logic [1:0]    idx_sel;
  logic [PB-1:0] t_sel;
  logic [PB+1:0] su;
  always_comb begin
    idx_sel = cmd.blep_start ? 2'd0 : idx_r + 2'd1;
    case (idx_sel)
      2'd0:    t_sel = p_r;
      2'd1:    t_sel = p_r - pw_r;
      default: t_sel = p_r - duty_r;
    endcase
    su = setup(t_sel, dt_r);
  end

  pbo_div #(.PHASE_BITS(PB)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dstart_r), .num(num_r), .den(dt_r),
    .quo(quo), .busy(dbusy), .done(ddone)
  );

  // num == den (phase exactly on the edge) gives a quotient of one,
  // which the 30 bit quotient cannot hold; its square is exactly one
  assign sq = quo * quo;
  always_comb begin
    bterm = full_r ? (VW'(1) <<< Q) : VW'(sq[2*Q-1:Q]);
    if (neg_r) bterm = -bterm;
    if (!act_r) bterm = '0;
  end

  logic last_done;
  assign last_done = ddone && idx_r == 2'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= '0;
      dstart_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      dstart_r <= 1'b0;
      if (cmd.load) begin
        acc_r  <= sum_c[PB-1:0];
        p_r    <= p_c;
        dt_r   <= dt_c;
        pw_r   <= pw_c;
        duty_r <= to_ph(duty_cfg);
        wrap_r <= sum_c[PB];
      end
      if (cmd.blep_start) begin
        idx_r <= 2'd0;
      end
      if (cmd.blep_start || (ddone && idx_r != 2'd2)) begin
        act_r    <= su[PB+1];
        neg_r    <= su[PB];
        num_r    <= su[PB-1:0];
        full_r   <= (su[PB-1:0] == dt_r);
        dstart_r <= 1'b1;
      end
      if (ddone) begin
        case (idx_r)
          2'd0:    b0_r <= bterm;
          2'd1:    b1_r <= bterm;
          default: b2_r <= bterm;
        endcase
        if (idx_r != 2'd2) idx_r <= idx_r + 2'd1;
      end
    end
  end

  // final sums and rounding
  function automatic logic signed [16:0] rnd(input logic signed [VW-1:0] v);
    logic signed [VW-1:0] r;
    r = (v + (VW'(1) <<< (SH - 1))) >>> SH;
    if (r > VW'(65535)) return 17'sd65535;
    if (r < -VW'(65536)) return -17'sd65536;
    return r[16:0];
  endfunction

  localparam logic signed [VW-1:0] QONE = VW'(1) <<< Q;
  logic signed [VW-1:0] pq, saw_v, pul_v, cor_v;
  always_comb begin
    pq = VW'((64'(p_r) << UP) >> DN);
    saw_v = 2 * pq - QONE - b0_r;
    pul_v = ((p_r < pw_r) ? QONE : -QONE) + b0_r - b1_r;
    cor_v = ((p_r < duty_r) ? QONE : -QONE) + b0_r - b2_r;
  end

  // result registers load only once the previous result has left
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      saw_out   <= rnd(saw_v);
      pulse_out <= rnd(pul_v);
      core_out  <= rnd(cor_v);
      wrapped   <= wrap_r;
    end
  end

  assign sts.div_busy = dbusy;
  assign sts.div_done = last_done;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    dstart_r |-> !dbusy) else $error("divider restarted while busy");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r != 2'd3) else $error("bad residual index");
  a_dt_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load) |-> dt_r <= STEP_MAX) else $error("step not clamped");
endmodule
`default_nettype wire

FILE: rtl/polyblep_oscillator_core.sv
// Top level: band-limited saw, pulse and core-square oscillator.
// Usage:
//  - in channel: one item per audio sample (phase_step, pulse_width,
//    restart, start_phase). in_ready is high while the controller is idle,
//    even with the previous result still waiting in the output register.
//  - out channel: one item per input item: saw_out, pulse_out, core_out
//    (Q3.14) and wrapped. It holds until out_ready is seen.
//  - cfg channel: writes core_duty (Q0.24); write only while idle.
// Sequencing: three residual quotients run one after another through a single
//  bit-serial divider, and out_valid rises when the result registers load after
//  the last one. in_ready returns on the edge that raises out_valid, so a new
//  item is accepted only once the previous one has reached the result registers.
// Reset (rst_n low, synchronous): phase accumulator cleared, core_duty
//  returns to one half, no result pending.
// Stall: while out_ready is low the result is held; one further item may be
//  accepted and computed, then it waits (in_ready low) until the held
//  result leaves.
`default_nettype none
module polyblep_oscillator_core #(
  parameter int PHASE_BITS    = 24,
  parameter int OUT_FRAC_BITS = 14
) (
  input wire logic     clk,
  input wire logic     rst_n,
  pbo_in_if.sink       in_ch,
  pbo_out_if.source    out_ch,
  pbo_cfg_if.sink      cfg_ch
);
  pbo_pkg::cmd_t cmd;
  pbo_pkg::sts_t sts;
  logic          busy;
  logic [23:0]   duty_r;
  logic          out_valid_r;
  logic          in_fire;

  assign in_ch.ready = !busy;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) duty_r <= 24'h800000;
    else if (cfg_ch.valid) duty_r <= cfg_ch.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end
  assign out_ch.valid = out_valid_r;

  pbo_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .out_free(!out_valid_r),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  pbo_dp #(.PHASE_BITS(PHASE_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .phase_step(in_ch.phase_step), .pulse_width(in_ch.pulse_width),
    .restart(in_ch.restart), .start_phase(in_ch.start_phase), .duty_cfg(duty_r),
    .saw_out(out_ch.saw_out), .pulse_out(out_ch.pulse_out),
    .core_out(out_ch.core_out), .wrapped(out_ch.wrapped)
  );

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !out_valid_r) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> out_valid_r) else $error("result dropped");
  a_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(out_ch.saw_out) && $stable(out_ch.core_out))
    else $error("result changed while held");
endmodule
`default_nettype wire
